[rtl/core/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared constants, codes and types of the lidar response deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 128;
  localparam int unsigned HEADER_BYTES  = 7;
  localparam int unsigned POS_W         = $clog2(PAYLOAD_DEPTH + HEADER_BYTES + 1);

  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned LEN_W  = 30;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned INFO_W = 32;

  localparam logic [KIND_W-1:0] KIND_BYTE         = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESTART_SYNC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART_DATA = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;
  localparam logic [3:0]        NIB_FIRST   = 4'hA;
  localparam logic [3:0]        NIB_SECOND  = 4'h5;

  typedef struct packed {
    logic              data_written;
    logic [IDX_W-1:0]  data_index;
    logic [BYTE_W-1:0] data_value;
    logic              data_kept;
    logic              frame_done;
    logic              overrun_error;
    logic [LEN_W-1:0]  payload_length;
    logic [MODE_W-1:0] send_mode;
    logic [BYTE_W-1:0] desc_type;
  } ldf_result_t;

endpackage

[rtl/core/ldf_in_if.sv]
// ----------------------------------------------------------------------------
// ldf_in_if
// Input channel: received bytes and restart items.
// ----------------------------------------------------------------------------
interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

[rtl/core/ldf_rsp_if.sv]
// ----------------------------------------------------------------------------
// ldf_rsp_if
// Result channel: one deframer result per input transfer.
// ----------------------------------------------------------------------------
interface ldf_rsp_if;
  logic        valid;
  logic        ready;
  logic        data_written;
  logic [6:0]  data_index;
  logic [7:0]  data_value;
  logic        data_kept;
  logic        frame_done;
  logic        overrun_error;
  logic [29:0] payload_length;
  logic [1:0]  send_mode;
  logic [7:0]  desc_type;

  modport source (output valid, data_written, data_index, data_value, data_kept,
                  frame_done, overrun_error, payload_length, send_mode, desc_type,
                  input ready);
  modport sink   (input valid, data_written, data_index, data_value, data_kept,
                  frame_done, overrun_error, payload_length, send_mode, desc_type,
                  output ready);
endinterface

[rtl/core/ldf_step.sv]
// ----------------------------------------------------------------------------
// ldf_step
// Deframer state and per-byte next-state logic: sync hunt, descriptor
// capture, payload indexing, express sync check, done and overrun.
// ----------------------------------------------------------------------------
module ldf_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      accept_i,
  input  logic [1:0]                kind_i,
  input  logic [7:0]                rx_byte_i,
  output ldf_pkg::ldf_result_t      result_o
);
  import ldf_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d, pos_inc, di;
  logic [INFO_W-1:0] info_q, info_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic              halted_q, halted_d;
  logic              esc_q;
  logic [LEN_W:0]    total;
  logic              kept;

  assign total   = {1'b0, info_q[LEN_W-1:0]} + (LEN_W+1)'(HEADER_BYTES);
  assign di      = pos_q - POS_W'(HEADER_BYTES);
  assign pos_inc = pos_q + POS_W'(1);
  assign kept    = !(esc_q && (((di == '0) && (rx_byte_i[7:4] != NIB_FIRST)) ||
                               ((di == POS_W'(1)) && (rx_byte_i[7:4] != NIB_SECOND))));

  always_comb begin
    pos_d    = pos_q;
    info_d   = info_q;
    type_d   = type_q;
    halted_d = halted_q;
    result_o = '0;
    unique case (kind_i)
      KIND_RESTART_SYNC: begin
        pos_d    = '0;
        halted_d = 1'b0;
      end
      KIND_RESTART_DATA: begin
        pos_d    = POS_W'(HEADER_BYTES);
        halted_d = 1'b0;
      end
      KIND_BYTE: begin
        if (!halted_q) begin
          priority if (pos_q == POS_W'(0)) begin
            if (rx_byte_i == SYNC_FIRST) pos_d = POS_W'(1);
          end else if (pos_q == POS_W'(1)) begin
            pos_d = (rx_byte_i == SYNC_SECOND) ? POS_W'(2) : POS_W'(0);
          end else if (pos_q == POS_W'(2)) begin
            info_d = {24'd0, rx_byte_i};
            pos_d  = POS_W'(3);
          end else if (pos_q == POS_W'(3)) begin
            info_d[15:8] = info_q[15:8] | rx_byte_i;
            pos_d        = pos_inc;
          end else if (pos_q == POS_W'(4)) begin
            info_d[23:16] = info_q[23:16] | rx_byte_i;
            pos_d         = pos_inc;
          end else if (pos_q == POS_W'(5)) begin
            info_d[31:24] = info_q[31:24] | rx_byte_i;
            pos_d         = pos_inc;
          end else if (pos_q == POS_W'(6)) begin
            type_d              = rx_byte_i;
            pos_d               = POS_W'(HEADER_BYTES);
            result_o.frame_done = (info_q[LEN_W-1:0] == '0);
          end else begin
            if (di >= POS_W'(PAYLOAD_DEPTH)) begin
              halted_d = 1'b1;
            end else begin
              result_o.data_written = 1'b1;
              result_o.data_index   = IDX_W'(di);
              result_o.data_value   = rx_byte_i;
              result_o.data_kept    = kept;
              if (kept) begin
                pos_d = pos_inc;
                if ((LEN_W+1)'(pos_inc) == total) begin
                  result_o.frame_done = 1'b1;
                end else if ((LEN_W+1)'(pos_inc) > total) begin
                  halted_d = 1'b1;
                end
              end else if (di == POS_W'(1)) begin
                pos_d = pos_q - POS_W'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    result_o.overrun_error  = halted_d;
    result_o.payload_length = info_d[LEN_W-1:0];
    result_o.send_mode      = info_d[INFO_W-1:LEN_W];
    result_o.desc_type      = type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      info_q   <= '0;
      type_q   <= '0;
      halted_q <= 1'b0;
      esc_q    <= 1'b0;
    end else begin
      if (cfg_we_i) esc_q <= cfg_wdata_i;
      if (accept_i) begin
        pos_q    <= pos_d;
        info_q   <= info_d;
        type_q   <= type_d;
        halted_q <= halted_d;
      end
    end
  end

endmodule

[rtl/core/ldf_out_reg.sv]
// ----------------------------------------------------------------------------
// ldf_out_reg
// Result register with valid/ready; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module ldf_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ldf_pkg::ldf_result_t result_i,
  output logic                 space_o,
  ldf_rsp_if.source            rsp_o
);
  import ldf_pkg::*;

  logic        valid_q;
  ldf_result_t res_q;

  assign space_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

  assign rsp_o.valid          = valid_q;
  assign rsp_o.data_written   = res_q.data_written;
  assign rsp_o.data_index     = res_q.data_index;
  assign rsp_o.data_value     = res_q.data_value;
  assign rsp_o.data_kept      = res_q.data_kept;
  assign rsp_o.frame_done     = res_q.frame_done;
  assign rsp_o.overrun_error  = res_q.overrun_error;
  assign rsp_o.payload_length = res_q.payload_length;
  assign rsp_o.send_mode      = res_q.send_mode;
  assign rsp_o.desc_type      = res_q.desc_type;

endmodule

[rtl/core/lidar_response_deframer_core.sv]
// ----------------------------------------------------------------------------
// lidar_response_deframer_core
// Result: valid in the cycle after the input transfer (result register).
// Throughput: 1 item per cycle while results are taken; state updates in the cycle of the transfer.
// Reset: async active low; sync hunt, descriptor cleared, not halted,
// express sync check off, no result pending.
// ----------------------------------------------------------------------------
module lidar_response_deframer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ldf_in_if.sink    rx_i,
  ldf_rsp_if.source rsp_o
);
  import ldf_pkg::*;

  logic        space;
  logic        accept;
  ldf_result_t result;

  assign rx_i.ready = space;
  assign accept     = rx_i.valid && space;

  ldf_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .kind_i      (rx_i.kind),
    .rx_byte_i   (rx_i.rx_byte),
    .result_o    (result)
  );

  ldf_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .space_o  (space),
    .rsp_o    (rsp_o)
  );

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.valid && rx_i.ready |=> rsp_o.valid)
    else $error("input transfer produced no result");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> rx_i.ready)
    else $error("input stalled with empty result register");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.valid && rx_i.ready &&
    (rx_i.kind == KIND_RESTART_SYNC || rx_i.kind == KIND_RESTART_DATA)
    |=> !rsp_o.overrun_error && !rsp_o.data_written)
    else $error("restart left overrun or wrote data");

endmodule
